// File: sv/lrf_pkg.sv
// Shared types and constants of the LCD rectangle fill byte sequencer.
package lrf_pkg;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_RASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  // Header byte positions within the command/window preamble.
  localparam logic [3:0] HS_CASET = 4'd0;
  localparam logic [3:0] HS_X0    = 4'd2;
  localparam logic [3:0] HS_X1    = 4'd4;
  localparam logic [3:0] HS_RASET = 4'd5;
  localparam logic [3:0] HS_Y0    = 4'd7;
  localparam logic [3:0] HS_Y1    = 4'd9;
  localparam logic [3:0] HS_RAMWR = 4'd10;
  localparam logic [3:0] HDR_LEN  = 4'd11;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [7:0] SCREEN_WIDTH_RST  = 8'd128;
  localparam logic [7:0] SCREEN_HEIGHT_RST = 8'd160;

  // One accepted beat after clipping, held in the front register.
  typedef struct packed {
    logic        action;
    logic [7:0]  x0;
    logic [7:0]  y0;
    logic [7:0]  x1;
    logic [7:0]  y1;
    logic [7:0]  cols;
    logic [7:0]  rows;
    logic [15:0] color;
  } item_t;

endpackage

// File: sv/lrf_ifs.sv
// Valid/ready channel interfaces for the input and result beats.
interface lrf_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  rect_x;
  logic [7:0]  rect_y;
  logic [7:0]  rect_w;
  logic [7:0]  rect_h;
  logic [15:0] fill_color;

  modport source (output valid, action, rect_x, rect_y, rect_w, rect_h, fill_color,
                  input ready);
  modport sink (input valid, action, rect_x, rect_y, rect_w, rect_h, fill_color,
                output ready);
endinterface

interface lrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last;

  modport source (output valid, out_byte, is_data, last, input ready);
  modport sink (input valid, out_byte, is_data, last, output ready);
endinterface

// File: sv/lrf_front.sv
// Input stage: clips a start rectangle and registers the accepted beat.
module lrf_front (
  input  logic          clk,
  input  logic          rst,
  lrf_in_if.sink        in_ch,
  input  logic [7:0]    screen_width,
  input  logic [7:0]    screen_height,
  input  logic          advance,
  output logic          item_valid,
  output lrf_pkg::item_t item
);

  typedef struct packed {
    logic [7:0] size;
    logic [7:0] last_pos;
    logic       nonempty;
  } clip_t;

  // A span running past the screen edge is cut to end on the last column/row.
  function automatic clip_t clip_dim(logic [7:0] pos, logic [7:0] len, logic [7:0] limit);
    clip_t      r;
    logic [8:0] sum;
    sum = {1'b0, pos} + {1'b0, len};
    if (sum > {1'b0, limit}) begin
      r.size     = limit - pos;
      r.last_pos = limit - 8'd1;
      r.nonempty = limit > pos;
    end else begin
      r.size     = len;
      r.last_pos = pos + len - 8'd1;
      r.nonempty = len != 8'd0;
    end
    return r;
  endfunction

  clip_t          cx;
  clip_t          cy;
  logic           load;
  logic           keep;
  lrf_pkg::item_t item_next;

  assign cx   = clip_dim(in_ch.rect_x, in_ch.rect_w, screen_width);
  assign cy   = clip_dim(in_ch.rect_y, in_ch.rect_h, screen_height);
  assign keep = cx.nonempty && cy.nonempty;

  assign in_ch.ready = !item_valid || advance;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    item_next.action = in_ch.action;
    item_next.x0     = in_ch.rect_x;
    item_next.y0     = in_ch.rect_y;
    item_next.x1     = cx.last_pos;
    item_next.y1     = cy.last_pos;
    item_next.cols   = keep ? cx.size : 8'd0;
    item_next.rows   = keep ? cy.size : 8'd0;
    item_next.color  = in_ch.fill_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_next;
    end
  end

endmodule

// File: sv/lrf_seq.sv
// Byte sequencer: header/pixel counters and the registered result beat.
module lrf_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  lrf_pkg::item_t item,
  output logic           advance,
  lrf_out_if.source      out_ch
);

  logic        busy;
  logic [3:0]  header_step;
  logic [7:0]  win_x0;
  logic [7:0]  win_y0;
  logic [7:0]  win_x1;
  logic [7:0]  win_y1;
  logic [7:0]  cols_left;
  logic [7:0]  rows_left;
  logic [7:0]  clipped_width;
  logic        low_half;
  logic [15:0] held_color;

  logic        fire;
  logic        start;
  logic        tick;
  logic        produce;
  logic [7:0]  res_byte;
  logic        res_data;
  logic        res_last;
  logic [7:0]  cols_dec;
  logic [7:0]  rows_dec;
  logic        row_done;

  assign advance = !out_ch.valid || out_ch.ready;
  assign fire    = item_valid && advance;
  assign start   = fire && (item.action == lrf_pkg::ACT_START) && !busy;
  assign tick    = fire && (item.action == lrf_pkg::ACT_TICK) && busy;
  assign produce = tick;

  assign cols_dec = (cols_left != 8'd0) ? cols_left - 8'd1 : cols_left;
  assign row_done = cols_dec == 8'd0;
  assign rows_dec = (row_done && rows_left != 8'd0) ? rows_left - 8'd1 : rows_left;

  always_comb begin
    res_byte = lrf_pkg::BYTE_ZERO;
    res_data = 1'b1;
    res_last = 1'b0;
    if (header_step < lrf_pkg::HDR_LEN) begin
      unique case (header_step)
        lrf_pkg::HS_CASET: begin
          res_byte = lrf_pkg::CMD_CASET;
          res_data = 1'b0;
        end
        lrf_pkg::HS_X0: res_byte = win_x0;
        lrf_pkg::HS_X1: res_byte = win_x1;
        lrf_pkg::HS_RASET: begin
          res_byte = lrf_pkg::CMD_RASET;
          res_data = 1'b0;
        end
        lrf_pkg::HS_Y0: res_byte = win_y0;
        lrf_pkg::HS_Y1: res_byte = win_y1;
        lrf_pkg::HS_RAMWR: begin
          res_byte = lrf_pkg::CMD_RAMWR;
          res_data = 1'b0;
          res_last = rows_left == 8'd0;
        end
        default: res_byte = lrf_pkg::BYTE_ZERO;
      endcase
    end else if (!low_half) begin
      res_byte = held_color[15:8];
    end else begin
      res_byte = held_color[7:0];
      res_last = rows_dec == 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      header_step <= 4'd0;
      low_half    <= 1'b0;
    end else if (start) begin
      busy        <= 1'b1;
      header_step <= 4'd0;
      low_half    <= 1'b0;
    end else if (tick) begin
      if (header_step < lrf_pkg::HDR_LEN) begin
        header_step <= header_step + 4'd1;
      end else begin
        low_half <= !low_half;
      end
      if (res_last) begin
        busy <= 1'b0;
      end
    end
  end

  // Window and counters; counters only move on the low color byte.
  always_ff @(posedge clk) begin
    if (start) begin
      win_x0        <= item.x0;
      win_y0        <= item.y0;
      win_x1        <= item.x1;
      win_y1        <= item.y1;
      clipped_width <= item.cols;
      cols_left     <= item.cols;
      rows_left     <= item.rows;
      held_color    <= item.color;
    end else if (tick && header_step >= lrf_pkg::HDR_LEN && low_half) begin
      cols_left <= row_done ? clipped_width : cols_dec;
      rows_left <= rows_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else begin
      out_ch.valid <= produce || (out_ch.valid && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_ch.out_byte <= res_byte;
      out_ch.is_data  <= res_data;
      out_ch.last     <= res_last;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    header_step <= lrf_pkg::HDR_LEN)
    else $error("header step ran past the header length");

  a_pixels_have_rows: assert property (@(posedge clk) disable iff (rst)
    busy && header_step == lrf_pkg::HDR_LEN |-> rows_left != 8'd0)
    else $error("pixel phase entered with no rows left");

  a_last_ends_busy: assert property (@(posedge clk) disable iff (rst)
    produce && res_last |=> !busy && out_ch.valid && out_ch.last)
    else $error("final byte did not end the sequence");

  a_no_beat_when_idle: assert property (@(posedge clk) disable iff (rst)
    !busy && !(out_ch.valid && !out_ch.ready) |=> !out_ch.valid)
    else $error("result beat produced while idle");

endmodule

// File: sv/lcd_rect_fill_byte_sequencer_core.sv
// Top level of the LCD rectangle fill byte sequencer with its register port.
//
// Usage: in_ch carries items. A beat with action start latches a rectangle
// and a fill color (clipped to screen_width/screen_height); each later beat
// with action tick yields exactly one result beat on out_ch: the column
// window command and data, the row window command and data, the memory
// write command, then high/low color bytes for every pixel. The final byte
// carries last. Ticks while idle and starts while a rectangle is running
// give no result.
// Pipeline: an accepted tick is held in the input register, and its result
// goes to the result register; one item is taken every cycle while out_ch
// does not stall (the sequencer counters sit between the two stages).
// When out_ch stalls, the result register holds and one more item may
// wait in the input register before in_ch.ready drops.
// Reset clears the sequencer to idle and restores screen 128 x 160.
// Registers: screen_width at byte address 0, screen_height at 4 (paddr[2]
// selects; the low address bits are not decoded). Write only while idle.
module lcd_rect_fill_byte_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  lrf_in_if.sink      in_ch,
  lrf_out_if.source   out_ch
);

  logic           reg_sel;
  logic           reg_write;
  logic [7:0]     screen_width;
  logic [7:0]     screen_height;
  logic           advance;
  logic           item_valid;
  lrf_pkg::item_t item;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= lrf_pkg::SCREEN_WIDTH_RST;
      screen_height <= lrf_pkg::SCREEN_HEIGHT_RST;
    end else if (reg_write) begin
      unique case (reg_sel)
        lrf_pkg::REG_SCREEN_WIDTH:  screen_width  <= pwdata[7:0];
        lrf_pkg::REG_SCREEN_HEIGHT: screen_height <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lrf_pkg::REG_SCREEN_WIDTH:  prdata = {24'd0, screen_width};
      lrf_pkg::REG_SCREEN_HEIGHT: prdata = {24'd0, screen_height};
      default:                    prdata = 32'd0;
    endcase
  end

  lrf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .advance       (advance),
    .item_valid    (item_valid),
    .item          (item)
  );

  lrf_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .out_ch     (out_ch)
  );

endmodule
